### hdl/mcls_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and codes for the max-cut one-flip local search block.
// Depends on nothing; the top level, the accumulator and the testbench import it.
package mcls_pkg;

    // Default sizing of the stores.
    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 4096;

    // Field widths.
    localparam int OP_W   = 3;
    localparam int VTX_W  = 10;
    localparam int WGT_W  = 16;
    localparam int CUT_W  = 32;
    localparam int FLIP_W = 20;
    localparam int PASS_W = 8;
    localparam int STAT_W = 2;
    localparam int VCNT_W = 11;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register reset values.
    localparam logic [VCNT_W-1:0] VCNT_RESET = 11'd1024;
    localparam logic [PASS_W-1:0] PLIM_RESET = 8'd255;

    // Saturation point of the flip counter.
    localparam logic [FLIP_W-1:0] FLIP_MAX = '1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_EDGE  = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_SIDE  = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_ORDER = 3'd3;
    localparam logic [OP_W-1:0] OP_RUN       = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_SIDE = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    // Register indexes, taken from byte address bit 2.
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_PASS_LIMIT   = 1'b1;

    // One input item.
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [VTX_W-1:0]        vertex_a;
        logic [VTX_W-1:0]        vertex_b;
        logic signed [WGT_W-1:0] edge_weight;
        logic                    side_in;
        logic [VTX_W-1:0]        position;
    } t_item;

    // One result item.
    typedef struct packed {
        logic                    side_out;
        logic signed [CUT_W-1:0] cut_weight;
        logic [FLIP_W-1:0]       flip_count;
        logic [PASS_W-1:0]       pass_count;
        logic [STAT_W-1:0]       status;
    } t_result;

    // One entry of the edge store.
    typedef struct packed {
        logic [VTX_W-1:0]        a;
        logic [VTX_W-1:0]        b;
        logic signed [WGT_W-1:0] w;
    } t_edge;

    // Control of the shared accumulator.
    typedef struct packed {
        logic clr;
        logic add;
        logic sub;
    } t_acc_ctl;

endpackage

### hdl/maxcut_one_flip_local_search.sv
`timescale 1ns / 1ps
// Top level of the max-cut one-flip local search: sequencer, stores and register port.
// Depends on mcls_pkg, mcls_ram and mcls_acc.
//
// An item is taken when start is high and busy is low; exactly one result follows,
// shown for one cycle with o_result_valid, and the receiver cannot hold it off.
// After reset the side store is cleared entry by entry with busy high.
// Load, read and unknown items pass the execute, store read and result states and
// return to idle with the result. A run's length is set by the single edge store
// port, which is scanned entry by entry for each visited vertex: an out-of-range
// slot is skipped, an in-range vertex reads all stored edges and spends an extra
// accumulate step on each usable incident edge, and the closing cut pass reads all
// stored edges with extra side reads and an accumulate step per usable edge.
module maxcut_one_flip_local_search #(
    parameter int MAX_VERTICES = mcls_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = mcls_pkg::DEF_MAX_EDGES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command channel
    input  logic                           start,
    output logic                           busy,
    input  mcls_pkg::t_item                i_item,
    // Result channel
    output logic                           o_result_valid,
    output mcls_pkg::t_result              o_result,
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mcls_pkg::APB_AW-1:0]    paddr,
    input  logic [mcls_pkg::APB_DW-1:0]    pwdata,
    output logic [mcls_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);
    import mcls_pkg::*;

    localparam int VA_W = $clog2(MAX_VERTICES);
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ET_W = $clog2(MAX_EDGES + 1);
    localparam int NC_W = $clog2(MAX_VERTICES + 1);
    localparam int N_W  = (NC_W < VCNT_W) ? NC_W : VCNT_W;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RESP_RD,
        S_RESP,
        S_RUN_INIT,
        S_SWEEP,
        S_VISIT_RD,
        S_VISIT_CHK,
        S_SIDE_LAT,
        S_SCAN_RD,
        S_SCAN_NB,
        S_SCAN_ACC,
        S_DECIDE,
        S_END_SWEEP,
        S_CUT_INIT,
        S_CUT_RD,
        S_CUT_SA,
        S_CUT_SB,
        S_CUT_ACC,
        S_FINISH
    } t_state;

    t_state                  r_state;
    logic [VCNT_W-1:0]       r_vcount;
    logic [PASS_W-1:0]       r_plimit;
    logic [VA_W-1:0]         r_clr;
    t_item                   r_item;
    logic [STAT_W-1:0]       r_status;
    logic [ET_W-1:0]         r_etotal;
    logic [ET_W-1:0]         r_eidx;
    logic [N_W-1:0]          r_pctr;
    logic [VTX_W-1:0]        r_v;
    logic                    r_vside;
    logic                    r_sa;
    logic                    r_flipped;
    logic signed [CUT_W-1:0] r_last_cut;
    logic [FLIP_W-1:0]       r_last_flips;
    logic [PASS_W-1:0]       r_last_passes;
    logic                    r_out_valid;
    t_result                 r_result;

    logic [N_W-1:0]          w_n;
    logic                    w_va_ok;
    logic                    w_vb_ok;
    logic                    w_pos_ok;
    logic                    w_full;
    logic                    w_usable;
    logic                    w_match;
    logic [VTX_W-1:0]        w_other;
    logic [ET_W-1:0]         w_e_next;
    logic                    w_e_last;
    logic [N_W-1:0]          w_p_next;
    logic                    w_p_last;
    logic [PASS_W-1:0]       w_pass_next;
    logic                    w_cfg_wr;

    // Store ports
    logic                    w_edge_we;
    logic                    w_edge_re;
    logic [EA_W-1:0]         w_edge_raddr;
    t_edge                   w_edge_wdata;
    t_edge                   w_edge_rd;
    logic                    w_side_we;
    logic [VA_W-1:0]         w_side_waddr;
    logic                    w_side_wdata;
    logic                    w_side_re;
    logic [VA_W-1:0]         w_side_raddr;
    logic                    w_side_rd;
    logic                    w_ord_we;
    logic                    w_ord_re;
    logic [VTX_W-1:0]        w_ord_rd;
    t_acc_ctl                w_acc_ctl;
    logic                    w_acc_pos;
    logic signed [CUT_W-1:0] w_acc_cut;

    // Register port: register index is byte address bit 2.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCNT_RESET;
            r_plimit <= PLIM_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_VERTEX_COUNT) begin
                r_vcount <= pwdata[VCNT_W-1:0];
            end else begin
                r_plimit <= pwdata[PASS_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_PASS_LIMIT) ? APB_DW'(r_plimit) : APB_DW'(r_vcount);

    // Effective vertex count and range checks.
    assign w_n = (32'(r_vcount) >= 32'(MAX_VERTICES)) ? N_W'(MAX_VERTICES) : N_W'(r_vcount);
    assign w_va_ok  = 32'(r_item.vertex_a) < 32'(w_n);
    assign w_vb_ok  = 32'(r_item.vertex_b) < 32'(w_n);
    assign w_pos_ok = 32'(r_item.position) < 32'(w_n);
    assign w_full   = 32'(r_etotal) >= 32'(MAX_EDGES);

    // Edge qualification against the vertex under test.
    assign w_usable = (32'(w_edge_rd.a) < 32'(w_n)) && (32'(w_edge_rd.b) < 32'(w_n))
                      && (w_edge_rd.a != w_edge_rd.b);
    assign w_match  = w_usable && ((w_edge_rd.a == r_v) || (w_edge_rd.b == r_v));
    assign w_other  = (w_edge_rd.a == r_v) ? w_edge_rd.b : w_edge_rd.a;

    // Loop counters.
    assign w_e_next    = r_eidx + 1'b1;
    assign w_e_last    = (w_e_next == r_etotal);
    assign w_p_next    = r_pctr + 1'b1;
    assign w_p_last    = (w_p_next == w_n);
    assign w_pass_next = r_last_passes + 1'b1;

    assign w_edge_wdata.a = r_item.vertex_a;
    assign w_edge_wdata.b = r_item.vertex_b;
    assign w_edge_wdata.w = r_item.edge_weight;
    assign w_edge_raddr   = EA_W'(r_eidx);

    // Store and accumulator control, decoded from the sequencer state.
    always_comb begin
        w_edge_we    = 1'b0;
        w_edge_re    = 1'b0;
        w_side_we    = 1'b0;
        w_side_waddr = VA_W'(r_item.vertex_a);
        w_side_wdata = r_item.side_in;
        w_side_re    = 1'b0;
        w_side_raddr = VA_W'(r_item.vertex_a);
        w_ord_we     = 1'b0;
        w_ord_re     = 1'b0;
        w_acc_ctl    = '0;
        case (r_state)
            S_CLEAR: begin
                w_side_we    = 1'b1;
                w_side_waddr = r_clr;
                w_side_wdata = 1'b0;
            end
            S_EXEC: begin
                case (r_item.operation)
                    OP_ADD_EDGE:  w_edge_we = w_va_ok && w_vb_ok && !w_full;
                    OP_SET_SIDE:  w_side_we = w_va_ok;
                    OP_SET_ORDER: w_ord_we  = w_va_ok && w_pos_ok;
                    default:      w_edge_we = 1'b0;
                endcase
            end
            S_RESP_RD: begin
                w_side_re = 1'b1;
            end
            S_VISIT_RD: begin
                w_ord_re = 1'b1;
            end
            S_VISIT_CHK: begin
                w_side_re     = 1'b1;
                w_side_raddr  = VA_W'(w_ord_rd);
                w_acc_ctl.clr = 1'b1;
            end
            S_SCAN_RD, S_CUT_RD: begin
                w_edge_re = 1'b1;
            end
            S_SCAN_NB: begin
                w_side_re    = w_match;
                w_side_raddr = VA_W'(w_other);
            end
            S_SCAN_ACC: begin
                w_acc_ctl.add = 1'b1;
                w_acc_ctl.sub = (w_side_rd != r_vside);
            end
            S_DECIDE: begin
                w_side_we    = w_acc_pos;
                w_side_waddr = VA_W'(r_v);
                w_side_wdata = !r_vside;
            end
            S_CUT_INIT: begin
                w_acc_ctl.clr = 1'b1;
            end
            S_CUT_SA: begin
                w_side_re    = w_usable;
                w_side_raddr = VA_W'(w_edge_rd.a);
            end
            S_CUT_SB: begin
                w_side_re    = 1'b1;
                w_side_raddr = VA_W'(w_edge_rd.b);
            end
            S_CUT_ACC: begin
                w_acc_ctl.add = (w_side_rd != r_sa);
            end
            default: begin
                w_acc_ctl = '0;
            end
        endcase
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr         <= '0;
            r_etotal      <= '0;
            r_last_cut    <= '0;
            r_last_flips  <= '0;
            r_last_passes <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            case (r_state)
                // Sweep zeros through the side store after reset.
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == VA_W'(MAX_VERTICES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_item  <= i_item;
                        r_state <= S_EXEC;
                    end
                end
                // Apply a load operation and work out its status.
                S_EXEC: begin
                    r_status <= STAT_OK;
                    r_state  <= S_RESP_RD;
                    case (r_item.operation)
                        OP_CLEAR: begin
                            r_etotal <= '0;
                        end
                        OP_ADD_EDGE: begin
                            if (!(w_va_ok && w_vb_ok)) begin
                                r_status <= STAT_RANGE;
                            end else if (w_full) begin
                                r_status <= STAT_FULL;
                            end else begin
                                r_etotal <= r_etotal + 1'b1;
                            end
                        end
                        OP_SET_SIDE, OP_READ_SIDE: begin
                            if (!w_va_ok) begin
                                r_status <= STAT_RANGE;
                            end
                        end
                        OP_SET_ORDER: begin
                            if (!(w_va_ok && w_pos_ok)) begin
                                r_status <= STAT_RANGE;
                            end
                        end
                        OP_RUN: begin
                            r_state <= S_RUN_INIT;
                        end
                        default: begin
                            r_status <= STAT_OK;
                        end
                    endcase
                end
                S_RESP_RD: begin
                    r_state <= S_RESP;
                end
                // Present the result for one cycle.
                S_RESP: begin
                    r_out_valid         <= 1'b1;
                    r_result.side_out   <= w_va_ok && w_side_rd;
                    r_result.cut_weight <= r_last_cut;
                    r_result.flip_count <= r_last_flips;
                    r_result.pass_count <= r_last_passes;
                    r_result.status     <= r_status;
                    r_state             <= S_IDLE;
                end
                S_RUN_INIT: begin
                    r_last_flips  <= '0;
                    r_last_passes <= '0;
                    r_state       <= (r_plimit == '0) ? S_CUT_INIT : S_SWEEP;
                end
                S_SWEEP: begin
                    r_flipped <= 1'b0;
                    r_pctr    <= '0;
                    r_state   <= (w_n == '0) ? S_END_SWEEP : S_VISIT_RD;
                end
                S_VISIT_RD: begin
                    r_state <= S_VISIT_CHK;
                end
                // Skip a slot whose vertex is out of range.
                S_VISIT_CHK: begin
                    if (32'(w_ord_rd) >= 32'(w_n)) begin
                        r_pctr  <= w_p_next;
                        r_state <= w_p_last ? S_END_SWEEP : S_VISIT_RD;
                    end else begin
                        r_v     <= w_ord_rd;
                        r_eidx  <= '0;
                        r_state <= S_SIDE_LAT;
                    end
                end
                S_SIDE_LAT: begin
                    r_vside <= w_side_rd;
                    r_state <= (r_etotal == '0) ? S_DECIDE : S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_NB;
                end
                S_SCAN_NB: begin
                    if (w_match) begin
                        r_state <= S_SCAN_ACC;
                    end else begin
                        r_eidx  <= w_e_next;
                        r_state <= w_e_last ? S_DECIDE : S_SCAN_RD;
                    end
                end
                S_SCAN_ACC: begin
                    r_eidx  <= w_e_next;
                    r_state <= w_e_last ? S_DECIDE : S_SCAN_RD;
                end
                // Flip the vertex when its sum is positive.
                S_DECIDE: begin
                    if (w_acc_pos) begin
                        r_flipped <= 1'b1;
                        if (r_last_flips != FLIP_MAX) begin
                            r_last_flips <= r_last_flips + 1'b1;
                        end
                    end
                    r_pctr  <= w_p_next;
                    r_state <= w_p_last ? S_END_SWEEP : S_VISIT_RD;
                end
                S_END_SWEEP: begin
                    r_last_passes <= w_pass_next;
                    if (r_flipped && (w_pass_next < r_plimit)) begin
                        r_state <= S_SWEEP;
                    end else begin
                        r_state <= S_CUT_INIT;
                    end
                end
                // Cut weight over all usable edges.
                S_CUT_INIT: begin
                    r_eidx  <= '0;
                    r_state <= (r_etotal == '0) ? S_FINISH : S_CUT_RD;
                end
                S_CUT_RD: begin
                    r_state <= S_CUT_SA;
                end
                S_CUT_SA: begin
                    if (w_usable) begin
                        r_state <= S_CUT_SB;
                    end else begin
                        r_eidx  <= w_e_next;
                        r_state <= w_e_last ? S_FINISH : S_CUT_RD;
                    end
                end
                S_CUT_SB: begin
                    r_sa    <= w_side_rd;
                    r_state <= S_CUT_ACC;
                end
                S_CUT_ACC: begin
                    r_eidx  <= w_e_next;
                    r_state <= w_e_last ? S_FINISH : S_CUT_RD;
                end
                S_FINISH: begin
                    r_last_cut <= w_acc_cut;
                    r_state    <= S_RESP_RD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

    // Edge store: endpoints and weight of every added edge.
    mcls_ram #(
        .WIDTH ($bits(t_edge)),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (EA_W'(r_etotal)),
        .i_wdata (w_edge_wdata),
        .i_re    (w_edge_re),
        .i_raddr (w_edge_raddr),
        .o_rdata (w_edge_rd)
    );

    // Side store: one partition bit per vertex.
    mcls_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VERTICES)
    ) u_side_ram (
        .i_clk   (i_clk),
        .i_we    (w_side_we),
        .i_waddr (w_side_waddr),
        .i_wdata (w_side_wdata),
        .i_re    (w_side_re),
        .i_raddr (w_side_raddr),
        .o_rdata (w_side_rd)
    );

    // Visit order store.
    mcls_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (w_ord_we),
        .i_waddr (VA_W'(r_item.position)),
        .i_wdata (r_item.vertex_a),
        .i_re    (w_ord_re),
        .i_raddr (VA_W'(r_pctr)),
        .o_rdata (w_ord_rd)
    );

    // Shared accumulator for flip sums and the cut weight.
    mcls_acc #(
        .MAX_EDGES (MAX_EDGES)
    ) u_acc (
        .i_clk      (i_clk),
        .i_ctl      (w_acc_ctl),
        .i_weight   (w_edge_rd.w),
        .o_positive (w_acc_pos),
        .o_cut      (w_acc_cut)
    );

endmodule

### hdl/mcls_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the edge, side and visit order stores.
module mcls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mcls_acc.sv
`timescale 1ns / 1ps
// Shared add/subtract accumulator used for the flip sums and for the cut weight.
// Depends on mcls_pkg.
module mcls_acc #(
    parameter int MAX_EDGES = mcls_pkg::DEF_MAX_EDGES
) (
    input  logic                                 i_clk,
    input  mcls_pkg::t_acc_ctl                   i_ctl,
    input  logic signed [mcls_pkg::WGT_W-1:0]    i_weight,
    output logic                                 o_positive,
    output logic signed [mcls_pkg::CUT_W-1:0]    o_cut
);
    import mcls_pkg::*;

    // Every stored edge contributes at most once to either sum.
    localparam int ACC_W = WGT_W + 1 + $clog2(MAX_EDGES + 1);
    localparam int SAT_W = (ACC_W > CUT_W) ? ACC_W : CUT_W + 1;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] w_ext;
    logic signed [ACC_W-1:0] w_term;
    logic signed [SAT_W-1:0] w_wide;
    logic signed [SAT_W-1:0] w_hi;
    logic signed [SAT_W-1:0] w_lo;
    logic signed [SAT_W-1:0] w_sat;

    // Sign-extended weight, negated when the neighbour lies on the other side.
    assign w_ext  = ACC_W'(i_weight);
    assign w_term = i_ctl.sub ? -w_ext : w_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.add) begin
            r_acc <= r_acc + w_term;
        end
    end

    // Strictly positive sum means the vertex gains by flipping.
    assign o_positive = !r_acc[ACC_W-1] && (r_acc != '0);

    // Clamp to the signed 32-bit range.
    assign w_wide = SAT_W'(r_acc);
    assign w_hi   = SAT_W'(32'sh7FFF_FFFF);
    assign w_lo   = SAT_W'(32'sh8000_0000);

    always_comb begin
        if (w_wide > w_hi) begin
            w_sat = w_hi;
        end else if (w_wide < w_lo) begin
            w_sat = w_lo;
        end else begin
            w_sat = w_wide;
        end
    end

    assign o_cut = CUT_W'(w_sat);

endmodule

### sim/tb_maxcut_one_flip_local_search.sv
`timescale 1ns / 1ps
// Self-checking testbench for the max-cut one-flip local search block.
// Depends on mcls_pkg and the block's RTL; an internal model predicts every result.
module tb_maxcut_one_flip_local_search;
    import mcls_pkg::*;

    localparam int N_MAX          = DEF_MAX_VERTICES;
    localparam int E_MAX          = DEF_MAX_EDGES;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_CYCLES = 4_000_000;
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_ITEMS    = 100;
    localparam int EDGE_CAP       = 32;
    localparam int SMALL_GRAPH    = 16;
    localparam int SHOW_LIMIT     = 10;

    // Operation codes with no defined meaning.
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_item             i_item;
    logic              o_result_valid;
    t_result           o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    maxcut_one_flip_local_search dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Model of the graph, the partition and the last search outcome.
    logic [VTX_W-1:0]        edge_end_a   [E_MAX];
    logic [VTX_W-1:0]        edge_end_b   [E_MAX];
    int                      edge_wt      [E_MAX];
    int unsigned             edge_count;
    logic                    side_of      [N_MAX];
    logic [VTX_W-1:0]        order_slot   [N_MAX];
    bit                      slot_written [N_MAX];
    logic signed [CUT_W-1:0] cut_now;
    logic [FLIP_W-1:0]       flips_now;
    logic [PASS_W-1:0]       passes_now;
    logic [VCNT_W-1:0]       vcount_reg;
    logic [PASS_W-1:0]       plimit_reg;

    t_result pending_results[$];
    int      error_count;
    int      shown_count;
    int      burst_left;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Global guard against a hung run.
    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned active_vertices();
        return (vcount_reg > N_MAX) ? N_MAX : vcount_reg;
    endfunction

    // An edge takes part in a sweep and in the cut only with both ends in range and distinct.
    function automatic bit edge_live(int unsigned e, int unsigned n);
        return edge_end_a[e] < n && edge_end_b[e] < n && edge_end_a[e] != edge_end_b[e];
    endfunction

    function automatic bit order_ready(int unsigned n);
        for (int p = 0; p < n; p++) begin
            if (!slot_written[p]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Sweeps the visit order until a sweep makes no flip or the pass limit is hit, then scores the cut.
    function automatic void search_and_score();
        int unsigned n;
        int unsigned passes;
        int unsigned flips;
        int unsigned v;
        int unsigned other;
        longint      gain;
        longint      cut;
        bit          any_flip;
        n        = active_vertices();
        passes   = 0;
        flips    = 0;
        any_flip = 1'b1;
        while (any_flip && passes < plimit_reg) begin
            any_flip = 1'b0;
            for (int p = 0; p < n; p++) begin
                v = 32'(order_slot[p]);
                if (v < n) begin
                    gain = 0;
                    for (int e = 0; e < edge_count; e++) begin
                        if (edge_live(e, n) && (edge_end_a[e] == v || edge_end_b[e] == v)) begin
                            other = (edge_end_a[e] == v) ? 32'(edge_end_b[e]) : 32'(edge_end_a[e]);
                            if (side_of[other] == side_of[v]) gain += edge_wt[e];
                            else gain -= edge_wt[e];
                        end
                    end
                    if (gain > 0) begin
                        side_of[v] = ~side_of[v];
                        any_flip   = 1'b1;
                        if (flips < FLIP_MAX) flips++;
                    end
                end
            end
            passes++;
        end
        cut = 0;
        for (int e = 0; e < edge_count; e++) begin
            if (edge_live(e, n) && side_of[edge_end_a[e]] != side_of[edge_end_b[e]])
                cut += edge_wt[e];
        end
        if (cut > 64'sd2147483647) cut = 64'sd2147483647;
        if (cut < -64'sd2147483648) cut = -64'sd2147483648;
        cut_now    = cut[CUT_W-1:0];
        flips_now  = flips[FLIP_W-1:0];
        passes_now = passes[PASS_W-1:0];
    endfunction

    // Applies one accepted command to the model and returns the result it should produce.
    function automatic t_result apply_item(t_item it);
        t_result           r;
        int unsigned       n;
        logic [STAT_W-1:0] st;
        n  = active_vertices();
        st = STAT_OK;
        case (it.operation)
            OP_CLEAR: begin
                edge_count = 0;
            end
            OP_ADD_EDGE: begin
                if (it.vertex_a >= n || it.vertex_b >= n) begin
                    st = STAT_RANGE;
                end else if (edge_count >= E_MAX) begin
                    st = STAT_FULL;
                end else begin
                    edge_end_a[edge_count] = it.vertex_a;
                    edge_end_b[edge_count] = it.vertex_b;
                    edge_wt[edge_count]    = int'(it.edge_weight);
                    edge_count++;
                end
            end
            OP_SET_SIDE: begin
                if (it.vertex_a >= n) st = STAT_RANGE;
                else side_of[it.vertex_a] = it.side_in;
            end
            OP_SET_ORDER: begin
                if (it.vertex_a >= n || it.position >= n) begin
                    st = STAT_RANGE;
                end else begin
                    order_slot[it.position]   = it.vertex_a;
                    slot_written[it.position] = 1'b1;
                end
            end
            OP_RUN: begin
                search_and_score();
            end
            OP_READ_SIDE: begin
                if (it.vertex_a >= n) st = STAT_RANGE;
            end
            default: begin
            end
        endcase
        r.side_out   = (it.vertex_a < n) ? side_of[it.vertex_a] : 1'b0;
        r.cut_weight = cut_now;
        r.flip_count = flips_now;
        r.pass_count = passes_now;
        r.status     = st;
        return r;
    endfunction

    function automatic t_item cmd(logic [OP_W-1:0] op, int va, int vb = 0, int w = 0,
                                  bit sd = 1'b0, int pos = 0);
        t_item c;
        c.operation   = op;
        c.vertex_a    = va[VTX_W-1:0];
        c.vertex_b    = vb[VTX_W-1:0];
        c.edge_weight = w[WGT_W-1:0];
        c.side_in     = sd;
        c.position    = pos[VTX_W-1:0];
        return c;
    endfunction

    // Mostly in-range vertices, with a share drawn from the whole field.
    function automatic logic [VTX_W-1:0] pick_vertex(int unsigned n);
        if (n == 0 || $urandom_range(99) < 12) return VTX_W'($urandom_range(N_MAX - 1));
        return VTX_W'($urandom_range(n - 1));
    endfunction

    function automatic t_item random_command();
        t_item       c;
        int unsigned n;
        int unsigned roll;
        n             = active_vertices();
        c.vertex_a    = pick_vertex(n);
        c.vertex_b    = pick_vertex(n);
        c.edge_weight = WGT_W'($urandom_range(16'hFFFF));
        c.side_in     = 1'($urandom_range(1));
        c.position    = pick_vertex(n);
        roll          = $urandom_range(99);
        // Edge growth is capped so that each run stays short; a run needs every visited slot written.
        if (roll < 30) c.operation = (edge_count >= EDGE_CAP) ? OP_CLEAR : OP_ADD_EDGE;
        else if (roll < 45) c.operation = OP_SET_SIDE;
        else if (roll < 55) c.operation = OP_SET_ORDER;
        else if (roll < 63)
            c.operation = (n <= SMALL_GRAPH && order_ready(n)) ? OP_RUN : OP_READ_SIDE;
        else if (roll < 82) c.operation = OP_READ_SIDE;
        else if (roll < 86) c.operation = OP_CLEAR;
        else if (roll < 90) c.operation = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;
        else c.operation = OP_SET_SIDE;
        return c;
    endfunction

    // Sender pacing: bursts of random length separated by random gaps, some of them empty.
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
    endtask

    // Presents one command and holds it until the transfer completes.
    task automatic send_item(input t_item it);
        pace();
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results = {pending_results, apply_item(it)};
    endtask

    // Stops sending and waits until every predicted result has been seen.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == REG_VERTEX_COUNT) vcount_reg = value[VCNT_W-1:0];
        else plimit_reg = value[PASS_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int count, input int limit);
        settle();
        write_reg(REG_VERTEX_COUNT, count);
        write_reg(REG_PASS_LIMIT, limit);
    endtask

    // Reset state with the full vertex range, the top vertex and the undefined codes.
    task automatic test_after_reset();
        send_item(cmd(OP_READ_SIDE, 0));
        send_item(cmd(OP_SET_SIDE, 1023, 0, 0, 1'b1));
        send_item(cmd(OP_READ_SIDE, 1023));
        send_item(cmd(OP_SPARE_6, 5));
        send_item(cmd(OP_SPARE_7, 1023, 1023, -1, 1'b1, 1023));
    endtask

    // A four-vertex graph with extreme weights, a self-loop and range errors.
    task automatic test_small_graph();
        configure(4, 255);
        send_item(cmd(OP_CLEAR, 0));
        send_item(cmd(OP_SET_ORDER, 3, 0, 0, 1'b0, 0));
        send_item(cmd(OP_SET_ORDER, 1, 0, 0, 1'b0, 1));
        send_item(cmd(OP_SET_ORDER, 0, 0, 0, 1'b0, 2));
        send_item(cmd(OP_SET_ORDER, 2, 0, 0, 1'b0, 3));
        send_item(cmd(OP_ADD_EDGE, 0, 1, 32767));
        send_item(cmd(OP_ADD_EDGE, 1, 2, -32768));
        send_item(cmd(OP_ADD_EDGE, 2, 3, 5));
        send_item(cmd(OP_ADD_EDGE, 3, 0, 7));
        send_item(cmd(OP_ADD_EDGE, 2, 2, 100));
        send_item(cmd(OP_ADD_EDGE, 0, 4, 1));
        send_item(cmd(OP_SET_ORDER, 1, 0, 0, 1'b0, 4));
        send_item(cmd(OP_RUN, 1));
        send_item(cmd(OP_READ_SIDE, 2));
        send_item(cmd(OP_RUN, 3));
    endtask

    // Edges and visit slots left behind when the vertex count shrinks; zero pass limit.
    task automatic test_stale_entries();
        configure(8, 0);
        send_item(cmd(OP_SET_ORDER, 6, 0, 0, 1'b0, 1));
        send_item(cmd(OP_SET_ORDER, 3, 0, 0, 1'b0, 4));
        send_item(cmd(OP_ADD_EDGE, 6, 3, 9));
        configure(5, 0);
        send_item(cmd(OP_RUN, 0));
        configure(5, 1);
        send_item(cmd(OP_RUN, 6));
    endtask

    // Vertex counts above the store size, zero and one.
    task automatic test_count_extremes();
        configure(2047, 1);
        send_item(cmd(OP_ADD_EDGE, 1023, 0, 1));
        send_item(cmd(OP_READ_SIDE, 1023));
        configure(0, 255);
        send_item(cmd(OP_ADD_EDGE, 0, 0, 3));
        send_item(cmd(OP_SET_SIDE, 0, 0, 0, 1'b1));
        send_item(cmd(OP_SET_ORDER, 0, 0, 0, 1'b0, 0));
        send_item(cmd(OP_RUN, 0));
        configure(1, 1);
        send_item(cmd(OP_RUN, 0));
    endtask

    // Fills the edge store on two vertices, then overflows it and runs on the full store.
    task automatic test_full_store();
        configure(2, 255);
        send_item(cmd(OP_CLEAR, 0));
        for (int e = 0; e < E_MAX; e++)
            send_item(cmd(OP_ADD_EDGE, $urandom_range(1), $urandom_range(1),
                          $urandom_range(16'hFFFF)));
        // The range check wins over the full store.
        send_item(cmd(OP_ADD_EDGE, 5, 0, 1));
        send_item(cmd(OP_ADD_EDGE, 0, 1, 1));
        send_item(cmd(OP_SET_ORDER, 0, 0, 0, 1'b0, 0));
        send_item(cmd(OP_SET_ORDER, 1, 0, 0, 1'b0, 1));
        send_item(cmd(OP_SET_SIDE, 1, 0, 0, 1'($urandom_range(1))));
        send_item(cmd(OP_RUN, 0));
        send_item(cmd(OP_CLEAR, 0));
    endtask

    // Phases with their own settings: a visit order first on small graphs, then a random mix of commands.
    task automatic test_random_phases();
        int unsigned n;
        int          count;
        int          limit;
        int          roll;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            count = (ph % 4 == 3) ? $urandom_range(SMALL_GRAPH + 1, 2047) : $urandom_range(1, 12);
            roll  = $urandom_range(9);
            if (roll < 7) limit = $urandom_range(1, 6);
            else if (roll == 7) limit = 255;
            else if (roll == 8) limit = 0;
            else limit = $urandom_range(255);
            configure(count, limit);
            n = active_vertices();
            if (n <= SMALL_GRAPH) begin
                for (int p = 0; p < n; p++)
                    send_item(cmd(OP_SET_ORDER, $urandom_range(n - 1), $urandom_range(1023),
                                  $urandom_range(16'hFFFF), 1'($urandom_range(1)), p));
            end
            repeat (PHASE_ITEMS) send_item(random_command());
        end
    endtask

    // Result checker: every strobed result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                error_count++;
                if (shown_count < SHOW_LIMIT) begin
                    shown_count++;
                    $display("%0t: result with no pending prediction", $time);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_result.side_out !== want.side_out || o_result.cut_weight !== want.cut_weight ||
                    o_result.flip_count !== want.flip_count ||
                    o_result.pass_count !== want.pass_count || o_result.status !== want.status) begin
                    error_count++;
                    if (shown_count < SHOW_LIMIT) begin
                        shown_count++;
                        $display("%0t: expected side %0b cut %0d flips %0d passes %0d status %0d",
                                 $time, want.side_out, want.cut_weight, want.flip_count,
                                 want.pass_count, want.status);
                        $display("%0t:      got side %0b cut %0d flips %0d passes %0d status %0d",
                                 $time, o_result.side_out, o_result.cut_weight,
                                 o_result.flip_count, o_result.pass_count, o_result.status);
                    end
                end
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        error_count = 0;
        shown_count = 0;
        burst_left  = 0;
        edge_count  = 0;
        cut_now     = '0;
        flips_now   = '0;
        passes_now  = '0;
        vcount_reg  = VCNT_RESET;
        plimit_reg  = PLIM_RESET;
        for (int v = 0; v < N_MAX; v++) begin
            side_of[v]      = 1'b0;
            order_slot[v]   = '0;
            slot_written[v] = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // The side store is cleared after reset; wait for the block to come free.
        do @(posedge i_clk); while (busy !== 1'b0);

        test_after_reset();
        test_small_graph();
        test_stale_entries();
        test_count_extremes();
        test_full_store();
        test_random_phases();

        settle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
